// ===== design/spcc_pkg.sv =====
// Shared package for the shape pair contact checker.
// Holds field widths, shape and status codes, and the request and response payload types.
// No dependencies.
`timescale 1ns / 1ps

package spcc_pkg;

   // Field widths
   localparam int COORD_BITS       = 24;
   localparam int EXTENT_BITS      = COORD_BITS - 1;
   localparam int NORMAL_FRAC_BITS = 14;
   localparam int NORMAL_BITS      = NORMAL_FRAC_BITS + 2;

   // Internal datapath widths
   localparam int DELTA_BITS = COORD_BITS + 1;         // centre difference
   localparam int ROOT_BITS  = COORD_BITS + 1;         // distance
   localparam int REM_BITS   = ROOT_BITS + 3;          // square root remainder
   localparam int QUO_BITS   = NORMAL_FRAC_BITS + 1;   // normal magnitude
   localparam int NUM_BITS   = COORD_BITS + NORMAL_FRAC_BITS + 1;
   localparam int DREM_BITS  = ROOT_BITS + 1;          // divider remainder

   // Unit normal, 1.0 in the normal format
   localparam logic signed [NORMAL_BITS-1:0] NORMAL_ONE =
      {2'b01, {NORMAL_FRAC_BITS{1'b0}}};

   typedef enum logic {
      KIND_RECT   = 1'b0,
      KIND_CIRCLE = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_NONE        = 2'd0,
      ST_CONTACT     = 2'd1,
      ST_UNSUPPORTED = 2'd2
   } status_type;

   typedef struct packed {
      kind_type                       first_kind;
      logic signed [COORD_BITS-1:0]   first_pos_x;
      logic signed [COORD_BITS-1:0]   first_pos_y;
      logic [EXTENT_BITS-1:0]         first_extent_x;
      logic [EXTENT_BITS-1:0]         first_extent_y;
      kind_type                       second_kind;
      logic signed [COORD_BITS-1:0]   second_pos_x;
      logic signed [COORD_BITS-1:0]   second_pos_y;
      logic [EXTENT_BITS-1:0]         second_extent_x;
      logic [EXTENT_BITS-1:0]         second_extent_y;
   } req_type;

   typedef struct packed {
      status_type                     status;
      logic signed [NORMAL_BITS-1:0]  normal_x;
      logic signed [NORMAL_BITS-1:0]  normal_y;
      logic [COORD_BITS-1:0]          penetration;
   } rsp_type;

endpackage

// ===== design/spcc_sqrt_cell.sv =====
// One cell of the square root chain: resolves one root bit per cycle while enabled.
// Consumes two radicand bits; carries side data along. Uses no package.
`timescale 1ns / 1ps

module spcc_sqrt_cell #(
   parameter int ROOT_W = 25,
   parameter int REM_W  = 28,
   parameter int SIDE_W = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [2*ROOT_W-1:0]   in_rad,
   input  logic [REM_W-1:0]      in_rem,
   input  logic [ROOT_W-1:0]     in_root,
   input  logic [SIDE_W-1:0]     in_side,
   output logic                  out_valid,
   output logic [2*ROOT_W-1:0]   out_rad,
   output logic [REM_W-1:0]      out_rem,
   output logic [ROOT_W-1:0]     out_root,
   output logic [SIDE_W-1:0]     out_side
);

   logic                vld_ff;
   logic [2*ROOT_W-1:0] rad_ff, rad_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [SIDE_W-1:0]   side_ff;
   logic [REM_W-1:0]    rem_x;
   logic [REM_W-1:0]    trial;

   // Restoring step: bring in two bits, try root*4+1
   always_comb begin
      rem_x  = {in_rem[REM_W-3:0], in_rad[2*ROOT_W-1 -: 2]};
      trial  = {{(REM_W-ROOT_W-2){1'b0}}, in_root, 2'b01};
      rad_in = {in_rad[2*ROOT_W-3:0], 2'b00};
      if (rem_x >= trial) begin
         rem_in  = rem_x - trial;
         root_in = {in_root[ROOT_W-2:0], 1'b1};
      end else begin
         rem_in  = rem_x;
         root_in = {in_root[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_valid;
      end
      if (en) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = vld_ff;
   assign out_rad   = rad_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_side  = side_ff;

endmodule

// ===== design/spcc_div_cell.sv =====
// One cell of the normal divider chain: one quotient bit per cycle on two lanes while enabled.
// Lanes share the divisor; side data rides along. Uses no package.
`timescale 1ns / 1ps

module spcc_div_cell #(
   parameter int DIV_W  = 25,
   parameter int REM_W  = 26,
   parameter int QUO_W  = 15,
   parameter int SIDE_W = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [DIV_W-1:0]           in_div,
   input  logic [1:0][REM_W-1:0]      in_rem,
   input  logic [1:0][QUO_W-1:0]      in_low,
   input  logic [1:0][QUO_W-1:0]      in_quo,
   input  logic [SIDE_W-1:0]          in_side,
   output logic                       out_valid,
   output logic [DIV_W-1:0]           out_div,
   output logic [1:0][REM_W-1:0]      out_rem,
   output logic [1:0][QUO_W-1:0]      out_low,
   output logic [1:0][QUO_W-1:0]      out_quo,
   output logic [SIDE_W-1:0]          out_side
);

   logic                  vld_ff;
   logic [DIV_W-1:0]      div_ff;
   logic [1:0][REM_W-1:0] rem_ff, rem_in;
   logic [1:0][QUO_W-1:0] low_ff, low_in;
   logic [1:0][QUO_W-1:0] quo_ff, quo_in;
   logic [SIDE_W-1:0]     side_ff;
   logic [1:0][REM_W-1:0] rem_x;
   logic [REM_W-1:0]      div_x;

   // Restoring divide step on each lane
   always_comb begin
      div_x = {{(REM_W-DIV_W){1'b0}}, in_div};
      for (int i = 0; i < 2; i++) begin
         rem_x[i]  = {in_rem[i][REM_W-2:0], in_low[i][QUO_W-1]};
         low_in[i] = {in_low[i][QUO_W-2:0], 1'b0};
         if (rem_x[i] >= div_x) begin
            rem_in[i] = rem_x[i] - div_x;
            quo_in[i] = {in_quo[i][QUO_W-2:0], 1'b1};
         end else begin
            rem_in[i] = rem_x[i];
            quo_in[i] = {in_quo[i][QUO_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_valid;
      end
      if (en) begin
         div_ff  <= in_div;
         rem_ff  <= rem_in;
         low_ff  <= low_in;
         quo_ff  <= quo_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = vld_ff;
   assign out_div   = div_ff;
   assign out_rem   = rem_ff;
   assign out_low   = low_ff;
   assign out_quo   = quo_ff;
   assign out_side  = side_ff;

endmodule

// ===== design/shape_pair_contact_check.sv =====
// Shape pair contact checker, top level.
// Accepts one pair per cycle while the output register is not held by an untaken result.
// The pipeline length is set by the square root chain (one bit per cell) and the divider chain.
// The whole chain advances together and holds only while a result waits untaken.
// Reset clears all valid flags; data registers are not reset.
`timescale 1ns / 1ps

module shape_pair_contact_check (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  spcc_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spcc_pkg::rsp_type rsp_payload
);

   import spcc_pkg::*;

   localparam int C = COORD_BITS;

   typedef struct packed {
      logic                        circ;
      logic                        mixed;
      logic signed [DELTA_BITS-1:0] dx;
      logic signed [DELTA_BITS-1:0] dy;
      logic [C-1:0]                rx;
      logic [C-1:0]                ry;
   } s1_type;

   typedef struct packed {
      logic           circ;
      logic           mixed;
      logic [2*C-1:0] sqx;
      logic [2*C-1:0] sqy;
      logic signed [C:0] hp;
      logic signed [C:0] vp;
      logic           negx;
      logic           zx;
      logic           negy;
      logic           zy;
      logic [C-1:0]   ax;
      logic [C-1:0]   ay;
      logic [C-1:0]   rx;
   } s2_type;

   typedef struct packed {
      logic         circ;
      rsp_type      rect;
      logic [C-1:0] ax;
      logic [C-1:0] ay;
      logic         negx;
      logic         negy;
      logic [C-1:0] rsum;
   } sq_side_type;

   typedef struct packed {
      logic         circ;
      rsp_type      rect;
      logic         contact;
      logic         dzero;
      logic         negx;
      logic         negy;
      logic [C-1:0] pen;
   } div_side_type;

   typedef struct packed {
      sq_side_type           side;
      logic [2*ROOT_BITS-1:0] rad;
   } s3_type;

   typedef struct packed {
      sq_side_type          side;
      logic [ROOT_BITS-1:0] d;
   } r1_type;

   typedef struct packed {
      div_side_type         side;
      logic [ROOT_BITS-1:0] d;
      logic [NUM_BITS-1:0]  numx;
      logic [NUM_BITS-1:0]  numy;
   } r2_type;

   localparam int SQ_SIDE_W  = $bits(sq_side_type);
   localparam int DIV_SIDE_W = $bits(div_side_type);

   logic en;

   logic   s1_vld_ff, s2_vld_ff, s3_vld_ff, r1_vld_ff, r2_vld_ff, rsp_vld_ff;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   r1_type r1_ff, r1_in;
   r2_type r2_ff, r2_in;
   rsp_type rsp_ff, rsp_in;

   // Chain moves whenever the output register is free or being emptied
   assign en        = !rsp_vld_ff || rsp_ready;
   assign req_ready = en;

   // Stage 1: centre differences and extent sums
   always_comb begin
      s1_in.circ  = (req_payload.first_kind == KIND_CIRCLE) &&
                    (req_payload.second_kind == KIND_CIRCLE);
      s1_in.mixed = req_payload.first_kind != req_payload.second_kind;
      s1_in.dx = {req_payload.second_pos_x[C-1], req_payload.second_pos_x} -
                 {req_payload.first_pos_x[C-1], req_payload.first_pos_x};
      s1_in.dy = {req_payload.second_pos_y[C-1], req_payload.second_pos_y} -
                 {req_payload.first_pos_y[C-1], req_payload.first_pos_y};
      s1_in.rx = {1'b0, req_payload.first_extent_x} + {1'b0, req_payload.second_extent_x};
      s1_in.ry = {1'b0, req_payload.first_extent_y} + {1'b0, req_payload.second_extent_y};
   end

   // Stage 2: magnitudes, squares and axis penetrations
   always_comb begin
      logic [DELTA_BITS-1:0] abx, aby;
      abx = s1_ff.dx[C] ? DELTA_BITS'(-s1_ff.dx) : s1_ff.dx;
      aby = s1_ff.dy[C] ? DELTA_BITS'(-s1_ff.dy) : s1_ff.dy;
      s2_in.circ  = s1_ff.circ;
      s2_in.mixed = s1_ff.mixed;
      s2_in.ax    = abx[C-1:0];
      s2_in.ay    = aby[C-1:0];
      s2_in.sqx   = {{C{1'b0}}, abx[C-1:0]} * {{C{1'b0}}, abx[C-1:0]};
      s2_in.sqy   = {{C{1'b0}}, aby[C-1:0]} * {{C{1'b0}}, aby[C-1:0]};
      s2_in.hp    = $signed({1'b0, s1_ff.rx}) - $signed({1'b0, abx[C-1:0]});
      s2_in.vp    = $signed({1'b0, s1_ff.ry}) - $signed({1'b0, aby[C-1:0]});
      s2_in.negx  = s1_ff.dx[C];
      s2_in.negy  = s1_ff.dy[C];
      s2_in.zx    = s1_ff.dx == '0;
      s2_in.zy    = s1_ff.dy == '0;
      s2_in.rx    = s1_ff.rx;
   end

   // Stage 3: unsupported pairing check, rectangle decision and squared distance
   always_comb begin
      logic hpos, vpos;
      hpos = !s2_ff.hp[C] && (s2_ff.hp != '0);
      vpos = !s2_ff.vp[C] && (s2_ff.vp != '0);
      s3_in.side.rect.status      = ST_NONE;
      s3_in.side.rect.normal_x    = '0;
      s3_in.side.rect.normal_y    = '0;
      s3_in.side.rect.penetration = '0;
      if (s2_ff.mixed) begin
         s3_in.side.rect.status = ST_UNSUPPORTED;
      end else if (!s2_ff.circ && hpos && vpos) begin
         s3_in.side.rect.status = ST_CONTACT;
         if (s2_ff.hp <= s2_ff.vp) begin
            s3_in.side.rect.normal_x    = s2_ff.zx ? '0 : (s2_ff.negx ? -NORMAL_ONE : NORMAL_ONE);
            s3_in.side.rect.penetration = s2_ff.hp[C-1:0];
         end else begin
            s3_in.side.rect.normal_y    = s2_ff.zy ? '0 : (s2_ff.negy ? -NORMAL_ONE : NORMAL_ONE);
            s3_in.side.rect.penetration = s2_ff.vp[C-1:0];
         end
      end
      s3_in.side.circ = s2_ff.circ;
      s3_in.side.ax   = s2_ff.ax;
      s3_in.side.ay   = s2_ff.ay;
      s3_in.side.negx = s2_ff.negx;
      s3_in.side.negy = s2_ff.negy;
      s3_in.side.rsum = s2_ff.rx;
      s3_in.rad       = {1'b0, ({1'b0, s2_ff.sqx} + {1'b0, s2_ff.sqy})};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
      if (en) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
      end
   end

   // Square root chain, one cell per root bit
   logic                   sq_vld  [0:ROOT_BITS];
   logic [2*ROOT_BITS-1:0] sq_rad  [0:ROOT_BITS];
   logic [REM_BITS-1:0]    sq_rem  [0:ROOT_BITS];
   logic [ROOT_BITS-1:0]   sq_root [0:ROOT_BITS];
   logic [SQ_SIDE_W-1:0]   sq_side [0:ROOT_BITS];

   assign sq_vld[0]  = s3_vld_ff;
   assign sq_rad[0]  = s3_ff.rad;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_side[0] = s3_ff.side;

   for (genvar i = 0; i < ROOT_BITS; i++) begin : g_sqrt
      spcc_sqrt_cell #(
         .ROOT_W (ROOT_BITS),
         .REM_W  (REM_BITS),
         .SIDE_W (SQ_SIDE_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (sq_vld[i]),
         .in_rad    (sq_rad[i]),
         .in_rem    (sq_rem[i]),
         .in_root   (sq_root[i]),
         .in_side   (sq_side[i]),
         .out_valid (sq_vld[i+1]),
         .out_rad   (sq_rad[i+1]),
         .out_rem   (sq_rem[i+1]),
         .out_root  (sq_root[i+1]),
         .out_side  (sq_side[i+1])
      );
   end

   // Round the root to nearest
   always_comb begin
      r1_in.side = sq_side[ROOT_BITS];
      if ({{(REM_BITS-ROOT_BITS){1'b0}}, sq_root[ROOT_BITS]} < sq_rem[ROOT_BITS]) begin
         r1_in.d = sq_root[ROOT_BITS] + 1'b1;
      end else begin
         r1_in.d = sq_root[ROOT_BITS];
      end
   end

   // Circle penetration and divider numerators
   always_comb begin
      logic signed [C+1:0] p;
      p = $signed({2'b00, r1_ff.side.rsum}) - $signed({1'b0, r1_ff.d});
      r2_in.side.circ    = r1_ff.side.circ;
      r2_in.side.rect    = r1_ff.side.rect;
      r2_in.side.contact = r1_ff.side.circ && !p[C+1] && (p != '0);
      r2_in.side.dzero   = r1_ff.d == '0;
      r2_in.side.negx    = r1_ff.side.negx;
      r2_in.side.negy    = r1_ff.side.negy;
      r2_in.side.pen     = p[C-1:0];
      r2_in.d            = r1_ff.d;
      r2_in.numx = {1'b0, r1_ff.side.ax, {NORMAL_FRAC_BITS{1'b0}}} +
                   NUM_BITS'(r1_ff.d[ROOT_BITS-1:1]);
      r2_in.numy = {1'b0, r1_ff.side.ay, {NORMAL_FRAC_BITS{1'b0}}} +
                   NUM_BITS'(r1_ff.d[ROOT_BITS-1:1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_vld_ff <= 1'b0;
         r2_vld_ff <= 1'b0;
      end else if (en) begin
         r1_vld_ff <= sq_vld[ROOT_BITS];
         r2_vld_ff <= r1_vld_ff;
      end
      if (en) begin
         r1_ff <= r1_in;
         r2_ff <= r2_in;
      end
   end

   // Divider chain, one cell per quotient bit, x and y lanes together
   logic                            dv_vld  [0:QUO_BITS];
   logic [ROOT_BITS-1:0]            dv_div  [0:QUO_BITS];
   logic [1:0][DREM_BITS-1:0]       dv_rem  [0:QUO_BITS];
   logic [1:0][QUO_BITS-1:0]        dv_low  [0:QUO_BITS];
   logic [1:0][QUO_BITS-1:0]        dv_quo  [0:QUO_BITS];
   logic [DIV_SIDE_W-1:0]           dv_side [0:QUO_BITS];

   assign dv_vld[0]    = r2_vld_ff;
   assign dv_div[0]    = r2_ff.d;
   assign dv_rem[0][0] = DREM_BITS'(r2_ff.numx[NUM_BITS-1:QUO_BITS]);
   assign dv_rem[0][1] = DREM_BITS'(r2_ff.numy[NUM_BITS-1:QUO_BITS]);
   assign dv_low[0][0] = r2_ff.numx[QUO_BITS-1:0];
   assign dv_low[0][1] = r2_ff.numy[QUO_BITS-1:0];
   assign dv_quo[0]    = '0;
   assign dv_side[0]   = r2_ff.side;

   for (genvar i = 0; i < QUO_BITS; i++) begin : g_div
      spcc_div_cell #(
         .DIV_W  (ROOT_BITS),
         .REM_W  (DREM_BITS),
         .QUO_W  (QUO_BITS),
         .SIDE_W (DIV_SIDE_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (dv_vld[i]),
         .in_div    (dv_div[i]),
         .in_rem    (dv_rem[i]),
         .in_low    (dv_low[i]),
         .in_quo    (dv_quo[i]),
         .in_side   (dv_side[i]),
         .out_valid (dv_vld[i+1]),
         .out_div   (dv_div[i+1]),
         .out_rem   (dv_rem[i+1]),
         .out_low   (dv_low[i+1]),
         .out_quo   (dv_quo[i+1]),
         .out_side  (dv_side[i+1])
      );
   end

   // Final selection: saturate and sign the circle normal, pick by pair kind
   always_comb begin
      div_side_type              fs;
      logic [NORMAL_BITS-1:0]    qx, qy;
      fs = dv_side[QUO_BITS];
      qx = {1'b0, dv_quo[QUO_BITS][0]};
      qy = {1'b0, dv_quo[QUO_BITS][1]};
      if (qx > NORMAL_ONE) qx = NORMAL_ONE;
      if (qy > NORMAL_ONE) qy = NORMAL_ONE;
      if (!fs.circ) begin
         rsp_in = fs.rect;
      end else if (!fs.contact) begin
         rsp_in.status      = ST_NONE;
         rsp_in.normal_x    = '0;
         rsp_in.normal_y    = '0;
         rsp_in.penetration = '0;
      end else begin
         rsp_in.status      = ST_CONTACT;
         rsp_in.penetration = fs.pen;
         if (fs.dzero) begin
            // coincident centres point along +x
            rsp_in.normal_x = NORMAL_ONE;
            rsp_in.normal_y = '0;
         end else begin
            rsp_in.normal_x = fs.negx ? -qx : qx;
            rsp_in.normal_y = fs.negy ? -qy : qy;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= dv_vld[QUO_BITS];
      end
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_vld_ff;
   assign rsp_payload = rsp_ff;

   // Checks
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   a_unsup_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ST_UNSUPPORTED |->
         rsp_payload.normal_x == '0 && rsp_payload.normal_y == '0 &&
         rsp_payload.penetration == '0)
      else $error("unsupported pairing carries a contact");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ST_NONE |->
         rsp_payload.normal_x == '0 && rsp_payload.normal_y == '0 &&
         rsp_payload.penetration == '0)
      else $error("no contact but non-zero result");

   a_contact_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ST_CONTACT |-> rsp_payload.penetration != '0)
      else $error("contact with zero penetration");

endmodule
